>>> src/lsa_pkg.sv
// Shared constants, payload types and controller/datapath links for the alignment scorer.
`default_nettype none
package lsa_pkg;

   localparam int MAX_REF_LEN   = 64;
   localparam int MAX_QUERY_LEN = 64;
   localparam int SYMBOL_BITS   = 8;

   localparam int REF_LEN_BITS    = $clog2(MAX_REF_LEN + 1);
   localparam int QUERY_LEN_BITS  = $clog2(MAX_QUERY_LEN + 1);
   localparam int REF_ADDR_BITS   = $clog2(MAX_REF_LEN);
   localparam int QUERY_ADDR_BITS = $clog2(MAX_QUERY_LEN);

   // field widths fixed by the interface
   localparam int OP_BITS    = 2;
   localparam int SYM_BITS   = 8;
   localparam int BEST_BITS  = 11;
   localparam int POS_BITS   = 7;
   localparam int GAP_BITS   = 6;
   localparam int MATCH_BITS = 5;
   localparam int MIS_BITS   = 6;
   localparam int CSR_BITS   = 6;
   localparam int CSR_IDX_BITS = 2;

   // internal score widths: stored signed scores and one guard bit for sums
   localparam int SCORE_BITS = 12;
   localparam int SUM_BITS   = SCORE_BITS + 1;

   localparam logic [OP_BITS-1:0] OP_REF   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_QUERY = 2'd1;
   localparam logic [OP_BITS-1:0] OP_RUN   = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FIRST_GAP = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GAP_STEP  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MATCH     = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MISMATCH  = 2'd3;

   typedef struct packed {
      logic [OP_BITS-1:0]  op;
      logic [SYM_BITS-1:0] symbol;
   } req_type;

   typedef struct packed {
      logic [BEST_BITS-1:0] best_score;
      logic [POS_BITS-1:0]  ref_end;
      logic [POS_BITS-1:0]  query_end;
      logic                 empty_input;
   } rsp_type;

   typedef struct packed {
      logic                       load_ref;
      logic                       load_query;
      logic                       fetch;
      logic                       calc;
      logic                       first_row;
      logic                       first_col;
      logic                       post;
      logic                       empty;
      logic [REF_ADDR_BITS-1:0]   ref_addr;
      logic [QUERY_ADDR_BITS-1:0] query_addr;
      logic [REF_LEN_BITS-1:0]    row_pos;
      logic [QUERY_LEN_BITS-1:0]  col_pos;
   } cmd_type;

   typedef struct packed {
      logic [REF_LEN_BITS-1:0]   ref_len;
      logic [QUERY_LEN_BITS-1:0] query_len;
      logic                      rsp_full;
   } stat_type;

endpackage
`default_nettype wire

>>> src/lsa_ctrl.sv
// Sequencer for loads and for the row-by-row walk of the score grid.
`default_nettype none
module lsa_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic [lsa_pkg::OP_BITS-1:0]   req_op,
   output logic                          req_stall,
   input  logic                          rsp_stall,
   input  lsa_pkg::stat_type             stat,
   output lsa_pkg::cmd_type              cmd
);
   import lsa_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_FETCH = 4'b0010,
      ST_CALC  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [REF_LEN_BITS-1:0]   row_ff, row_in;
   logic [QUERY_LEN_BITS-1:0] col_ff, col_in;
   logic                      empty_ff, empty_in;
   logic                      accept;
   logic [REF_LEN_BITS-1:0]   row_less;
   logic [QUERY_LEN_BITS-1:0] col_less;

   assign row_less = row_ff - REF_LEN_BITS'(1);
   assign col_less = col_ff - QUERY_LEN_BITS'(1);

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      empty_in = empty_ff;
      req_stall = (state_ff != ST_IDLE);
      accept   = req_valid && !req_stall;

      cmd            = '0;
      cmd.first_row  = (row_ff == REF_LEN_BITS'(1));
      cmd.first_col  = (col_ff == QUERY_LEN_BITS'(1));
      cmd.empty      = empty_ff;
      cmd.ref_addr   = row_less[REF_ADDR_BITS-1:0];
      cmd.query_addr = col_less[QUERY_ADDR_BITS-1:0];
      cmd.row_pos    = row_ff;
      cmd.col_pos    = col_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_REF:   cmd.load_ref = 1'b1;
                  OP_QUERY: cmd.load_query = 1'b1;
                  OP_RUN: begin
                     row_in = REF_LEN_BITS'(1);
                     col_in = QUERY_LEN_BITS'(1);
                     if (stat.ref_len == '0 || stat.query_len == '0) begin
                        empty_in = 1'b1;
                        state_in = ST_DONE;
                     end else begin
                        empty_in = 1'b0;
                        state_in = ST_FETCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_CALC;
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_FETCH;
            if (col_ff == stat.query_len) begin
               col_in = QUERY_LEN_BITS'(1);
               if (row_ff == stat.ref_len) begin
                  state_in = ST_DONE;
               end else begin
                  row_in = row_ff + REF_LEN_BITS'(1);
               end
            end else begin
               col_in = col_ff + QUERY_LEN_BITS'(1);
            end
         end
         ST_DONE: begin
            // hold until the result register is free
            if (!stat.rsp_full || !rsp_stall) begin
               cmd.post = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         empty_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         empty_ff <= empty_in;
      end
      row_ff <= row_in;
      col_ff <= col_in;
   end

endmodule
`default_nettype wire

>>> src/lsa_datapath.sv
// Symbol stores, row buffers, cell arithmetic, best-cell tracking and the result register.
`default_nettype none
module lsa_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [lsa_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [lsa_pkg::CSR_BITS-1:0]      csr_wdata,
   input  logic [lsa_pkg::SYM_BITS-1:0]      req_symbol,
   input  lsa_pkg::cmd_type                  cmd,
   output lsa_pkg::stat_type                 stat,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lsa_pkg::rsp_type                  rsp_data
);
   import lsa_pkg::*;

   localparam logic signed [SCORE_BITS-1:0] NO_GAP = {1'b1, {(SCORE_BITS-1){1'b0}}};
   localparam logic signed [SUM_BITS-1:0]   NO_GAP_W = {1'b1, NO_GAP};

   logic [GAP_BITS-1:0]   first_gap_ff, gap_step_ff;
   logic [MATCH_BITS-1:0] match_ff;
   logic [MIS_BITS-1:0]   mismatch_ff;

   logic [SYMBOL_BITS-1:0] ref_mem   [MAX_REF_LEN];
   logic [SYMBOL_BITS-1:0] query_mem [MAX_QUERY_LEN];
   logic [SCORE_BITS-1:0]  row_mem   [MAX_QUERY_LEN];
   logic [SCORE_BITS-1:0]  vgap_mem  [MAX_QUERY_LEN];

   logic [REF_LEN_BITS-1:0]   ref_len_ff;
   logic [QUERY_LEN_BITS-1:0] query_len_ff;

   logic [SYMBOL_BITS-1:0]        ref_rd_ff, query_rd_ff;
   logic signed [SCORE_BITS-1:0]  row_rd_ff, vgap_rd_ff;
   logic signed [SCORE_BITS-1:0]  diag_ff, left_ff, horiz_ff;
   logic [BEST_BITS-1:0]          best_ff;
   logic [REF_LEN_BITS-1:0]       best_row_ff;
   logic [QUERY_LEN_BITS-1:0]     best_col_ff;
   logic                          rsp_valid_ff;
   rsp_type                       rsp_ff;

   logic signed [SUM_BITS-1:0] open_w, ext_w, score_w;
   logic signed [SUM_BITS-1:0] up_w, vg_w, left_w, hz_w, diag_w;
   logic signed [SUM_BITS-1:0] va, vb, vert_w, ha, hb, horiz_w, dsum, h_w;
   logic                       take_best;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_gap_ff <= GAP_BITS'(3);
         gap_step_ff  <= GAP_BITS'(2);
         match_ff     <= MATCH_BITS'(1);
         mismatch_ff  <= '1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FIRST_GAP: first_gap_ff <= csr_wdata[GAP_BITS-1:0];
            CSR_GAP_STEP:  gap_step_ff  <= csr_wdata[GAP_BITS-1:0];
            CSR_MATCH:     match_ff     <= csr_wdata[MATCH_BITS-1:0];
            CSR_MISMATCH:  mismatch_ff  <= csr_wdata[MIS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // lengths: appends past capacity are dropped, a posted result clears both
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_len_ff   <= '0;
         query_len_ff <= '0;
      end else if (cmd.post) begin
         ref_len_ff   <= '0;
         query_len_ff <= '0;
      end else begin
         if (cmd.load_ref && ref_len_ff < REF_LEN_BITS'(MAX_REF_LEN))
            ref_len_ff <= ref_len_ff + REF_LEN_BITS'(1);
         if (cmd.load_query && query_len_ff < QUERY_LEN_BITS'(MAX_QUERY_LEN))
            query_len_ff <= query_len_ff + QUERY_LEN_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_ref && ref_len_ff < REF_LEN_BITS'(MAX_REF_LEN))
         ref_mem[ref_len_ff[REF_ADDR_BITS-1:0]] <= req_symbol[SYMBOL_BITS-1:0];
      if (cmd.fetch)
         ref_rd_ff <= ref_mem[cmd.ref_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_query && query_len_ff < QUERY_LEN_BITS'(MAX_QUERY_LEN))
         query_mem[query_len_ff[QUERY_ADDR_BITS-1:0]] <= req_symbol[SYMBOL_BITS-1:0];
      if (cmd.fetch)
         query_rd_ff <= query_mem[cmd.query_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.calc)
         row_mem[cmd.query_addr] <= h_w[SCORE_BITS-1:0];
      if (cmd.fetch)
         row_rd_ff <= row_mem[cmd.query_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.calc)
         vgap_mem[cmd.query_addr] <= vert_w[SCORE_BITS-1:0];
      if (cmd.fetch)
         vgap_rd_ff <= vgap_mem[cmd.query_addr];
   end

   // cell arithmetic; the first row and column see the grid border
   always_comb begin
      open_w  = {{(SUM_BITS-GAP_BITS){1'b0}}, first_gap_ff};
      ext_w   = {{(SUM_BITS-GAP_BITS){1'b0}}, gap_step_ff};
      if (ref_rd_ff == query_rd_ff)
         score_w = {{(SUM_BITS-MATCH_BITS){1'b0}}, match_ff};
      else
         score_w = {{(SUM_BITS-MIS_BITS){mismatch_ff[MIS_BITS-1]}}, mismatch_ff};

      up_w   = cmd.first_row ? '0 : {row_rd_ff[SCORE_BITS-1], row_rd_ff};
      vg_w   = cmd.first_row ? NO_GAP_W : {vgap_rd_ff[SCORE_BITS-1], vgap_rd_ff};
      left_w = cmd.first_col ? '0 : {left_ff[SCORE_BITS-1], left_ff};
      hz_w   = cmd.first_col ? NO_GAP_W : {horiz_ff[SCORE_BITS-1], horiz_ff};
      diag_w = cmd.first_col ? '0 : {diag_ff[SCORE_BITS-1], diag_ff};

      va = up_w - open_w;
      vb = vg_w - ext_w;
      vert_w = (va > vb) ? va : vb;
      if (vert_w < NO_GAP_W)
         vert_w = NO_GAP_W;

      ha = left_w - open_w;
      hb = hz_w - ext_w;
      horiz_w = (ha > hb) ? ha : hb;
      if (horiz_w < NO_GAP_W)
         horiz_w = NO_GAP_W;

      dsum = diag_w + score_w;
      h_w  = (dsum > 0) ? dsum : '0;
      if (vert_w > h_w)
         h_w = vert_w;
      if (horiz_w > h_w)
         h_w = horiz_w;

      take_best = (cmd.first_row && cmd.first_col) || (h_w[BEST_BITS-1:0] > best_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         diag_ff  <= up_w[SCORE_BITS-1:0];
         left_ff  <= h_w[SCORE_BITS-1:0];
         horiz_ff <= horiz_w[SCORE_BITS-1:0];
         if (take_best) begin
            best_ff     <= h_w[BEST_BITS-1:0];
            best_row_ff <= cmd.row_pos;
            best_col_ff <= cmd.col_pos;
         end
      end
   end

   // result register: load on post, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.post) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.post) begin
         rsp_ff.empty_input <= cmd.empty;
         rsp_ff.best_score  <= cmd.empty ? '0 : best_ff;
         rsp_ff.ref_end     <= cmd.empty ? '0 : POS_BITS'(best_row_ff);
         rsp_ff.query_end   <= cmd.empty ? '0 : POS_BITS'(best_col_ff);
      end
   end

   assign stat.ref_len   = ref_len_ff;
   assign stat.query_len = query_len_ff;
   assign stat.rsp_full  = rsp_valid_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_ff;

endmodule
`default_nettype wire

>>> src/local_alignment_scorer.sv
// Top level of the local alignment scorer: controller, datapath and checks.
//
//  channel  direction  handshake          payload
//  req      in         req_valid/stall    op, symbol
//  rsp      out        rsp_valid/stall    best_score, ref_end, query_end, empty_input
//  csr      in         csr_write          csr_index, csr_wdata
//
// A symbol load leaves the block idle; a run walks the R by Q grid row by row, with
// fetch and calc per cell, as each cell reads and writes the single-port row buffers.
// A run with an empty sequence goes straight to the done state and posts an empty result.
// Reset is synchronous; no clearing pass is needed, the first row sees the border.
// A stalled result is held in its register and loads are still taken meanwhile.
`default_nettype none
module local_alignment_scorer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  lsa_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lsa_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write,
   input  logic [lsa_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [lsa_pkg::CSR_BITS-1:0]      csr_wdata
);
   import lsa_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   lsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   lsa_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_symbol (req_data.symbol),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // an accepted run keeps the request side stalled in the next cycle
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.op == OP_RUN) |=> req_stall)
      else $error("run request did not make the block busy");

   // a new result only follows a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a run");

   // a non-empty result always names a real cell
   a_end_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.empty_input) |-> (rsp_data.ref_end != '0 &&
                                                rsp_data.query_end != '0))
      else $error("best cell position is zero");

endmodule
`default_nettype wire

>>> tb/sv/tb_local_alignment_scorer.sv
// Testbench for the local alignment scorer: predicts each run's best cell and checks results.
module tb_local_alignment_scorer;
   timeunit 1ns;
   timeprecision 1ps;
   import lsa_pkg::*;

   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
   localparam int NO_GAP          = -2048;
   localparam int PHASE_ITEMS     = 205;
   localparam int SETTLE_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT  = 30000;

   class alignment_scoreboard;
      logic [GAP_BITS-1:0]        open_penalty;
      logic [GAP_BITS-1:0]        gap_extend;
      logic [MATCH_BITS-1:0]      match_gain;
      logic signed [MIS_BITS-1:0] mismatch_gain;
      logic [SYM_BITS-1:0]        ref_syms[MAX_REF_LEN];
      logic [SYM_BITS-1:0]        query_syms[MAX_QUERY_LEN];
      int                         ref_len;
      int                         query_len;
      rsp_type                    expected_scores[$];
      int                         errors;

      function new();
         open_penalty  = 6'd3;
         gap_extend    = 6'd2;
         match_gain    = 5'd1;
         mismatch_gain = -6'sd1;
         ref_len       = 0;
         query_len     = 0;
         errors        = 0;
      endfunction

      function void set_register(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_BITS-1:0] value);
         case (idx)
            CSR_FIRST_GAP: open_penalty  = value;
            CSR_GAP_STEP:  gap_extend    = value;
            CSR_MATCH:     match_gain    = value[MATCH_BITS-1:0];
            CSR_MISMATCH:  mismatch_gain = value;
            default: ;
         endcase
      endfunction

      function int max_of(int a, int b);
         return (a > b) ? a : b;
      endfunction

      // fill the grid row by row, keeping one score row and the running vertical gaps
      function rsp_type score_grid();
         int prev_row[MAX_QUERY_LEN+1];
         int vert_best[MAX_QUERY_LEN+1];
         int mis, best, best_r, best_q, diag, left, horiz, up, sub, vert, h;
         rsp_type res;
         mis    = mismatch_gain;
         best   = -1;
         best_r = 0;
         best_q = 0;
         for (int c = 0; c <= query_len; c++) begin
            prev_row[c]  = 0;
            vert_best[c] = NO_GAP;
         end
         for (int r = 1; r <= ref_len; r++) begin
            diag  = prev_row[0];
            left  = 0;
            horiz = NO_GAP;
            for (int c = 1; c <= query_len; c++) begin
               up    = prev_row[c];
               sub   = (ref_syms[r-1] == query_syms[c-1]) ? int'(match_gain) : mis;
               vert  = max_of(max_of(up - int'(open_penalty), vert_best[c] - int'(gap_extend)),
                              NO_GAP);
               horiz = max_of(max_of(left - int'(open_penalty), horiz - int'(gap_extend)),
                              NO_GAP);
               h = max_of(0, diag + sub);
               h = max_of(h, max_of(vert, horiz));
               vert_best[c] = vert;
               diag         = up;
               prev_row[c]  = h;
               left         = h;
               if (h > best) begin
                  best   = h;
                  best_r = r;
                  best_q = c;
               end
            end
         end
         res.best_score  = BEST_BITS'(best);
         res.ref_end     = POS_BITS'(best_r);
         res.query_end   = POS_BITS'(best_q);
         res.empty_input = 1'b0;
         return res;
      endfunction

      function void note_request(req_type req);
         rsp_type res;
         case (req.op)
            OP_REF: begin
               if (ref_len < MAX_REF_LEN) begin
                  ref_syms[ref_len] = req.symbol;
                  ref_len++;
               end
            end
            OP_QUERY: begin
               if (query_len < MAX_QUERY_LEN) begin
                  query_syms[query_len] = req.symbol;
                  query_len++;
               end
            end
            OP_RUN: begin
               if (ref_len == 0 || query_len == 0) begin
                  res = '0;
                  res.empty_input = 1'b1;
               end else begin
                  res = score_grid();
               end
               expected_scores = {expected_scores, res};
               ref_len   = 0;
               query_len = 0;
            end
            default: ;
         endcase
      endfunction

      function void report(string field, int want, int got);
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         errors++;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_scores.size() == 0) begin
            $display("%0t: unexpected result, got %p", $time, got);
            errors++;
            return;
         end
         want = expected_scores.pop_front();
         if (got.best_score !== want.best_score)
            report("best_score", want.best_score, got.best_score);
         if (got.ref_end !== want.ref_end)
            report("ref_end", want.ref_end, got.ref_end);
         if (got.query_end !== want.query_end)
            report("query_end", want.query_end, got.query_end);
         if (got.empty_input !== want.empty_input)
            report("empty_input", want.empty_input, got.empty_input);
      endfunction

      function int pending();
         return expected_scores.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_write = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_BITS-1:0]     csr_wdata = '0;

   alignment_scoreboard sb = new();
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int issued        = 0;
   int quiet_cycles  = 0;

   local_alignment_scorer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // check results before noting requests: a run accepted this edge cannot answer yet
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_data);
         if (req_valid && !req_stall)
            sb.note_request(req_data);
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_request(input logic [OP_BITS-1:0] op, input logic [SYM_BITS-1:0] sym);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {op, sym};
      do @(posedge clock); while (req_stall);
      if (op != OP_UNUSED)
         issued++;
   endtask

   // hold off until every result is back and the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [CSR_BITS-1:0] open_cost, step_cost, match, mismatch);
      csr_write <= 1'b1;
      csr_index <= CSR_FIRST_GAP;
      csr_wdata <= open_cost;
      @(posedge clock);
      csr_index <= CSR_GAP_STEP;
      csr_wdata <= step_cost;
      @(posedge clock);
      csr_index <= CSR_MATCH;
      csr_wdata <= match;
      @(posedge clock);
      csr_index <= CSR_MISMATCH;
      csr_wdata <= mismatch;
      @(posedge clock);
      csr_write <= 1'b0;
      sb.set_register(CSR_FIRST_GAP, open_cost);
      sb.set_register(CSR_GAP_STEP, step_cost);
      sb.set_register(CSR_MATCH, match);
      sb.set_register(CSR_MISMATCH, mismatch);
   endtask

   function automatic logic [SYM_BITS-1:0] pick_symbol(bit narrow, logic [SYM_BITS-1:0] base);
      return narrow ? (base ^ SYM_BITS'($urandom_range(0, 3)))
                    : SYM_BITS'($urandom_range(0, 255));
   endfunction

   // load a reference and a related query in random order, then run; some calls send only random requests
   task automatic random_sequence(input bit force_full);
      int roll, n_ref, n_query, shift, ri, qi;
      bit narrow;
      logic [SYM_BITS-1:0] base;
      logic [SYM_BITS-1:0] ref_syms[$];
      logic [SYM_BITS-1:0] query_syms[$];
      roll   = $urandom_range(0, 99);
      narrow = ($urandom_range(0, 99) < 70);
      base   = SYM_BITS'($urandom_range(0, 255));
      if (!force_full && roll >= 8 && roll < 14) begin
         repeat ($urandom_range(1, 5))
            send_request(OP_BITS'($urandom_range(0, 3)), SYM_BITS'($urandom_range(0, 255)));
         return;
      end
      if (force_full || roll < 2) begin
         n_ref   = $urandom_range(60, 70);
         n_query = $urandom_range(60, 70);
      end else if (roll < 8) begin
         n_ref   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 5);
         n_query = (n_ref == 0) ? $urandom_range(0, 5) : 0;
      end else begin
         n_ref   = $urandom_range(1, 12);
         n_query = $urandom_range(1, 12);
      end
      for (int k = 0; k < n_ref; k++)
         ref_syms = {ref_syms, pick_symbol(narrow, base)};
      shift = $urandom_range(0, 8);
      for (int k = 0; k < n_query; k++) begin
         if (n_ref > 0 && $urandom_range(0, 99) < 65)
            query_syms = {query_syms, ref_syms[(k + shift) % n_ref]};
         else
            query_syms = {query_syms, pick_symbol(narrow, base)};
      end
      ri = 0;
      qi = 0;
      while (ri < n_ref || qi < n_query) begin
         if (qi == n_query || (ri < n_ref && $urandom_range(0, 1))) begin
            send_request(OP_REF, ref_syms[ri]);
            ri++;
         end else begin
            send_request(OP_QUERY, query_syms[qi]);
            qi++;
         end
         if ($urandom_range(0, 49) == 0)
            send_request(OP_UNUSED, SYM_BITS'($urandom_range(0, 255)));
      end
      send_request(OP_RUN, SYM_BITS'($urandom_range(0, 255)));
      if ($urandom_range(0, 19) == 0)
         settle();
   endtask

   task automatic run_phase(input logic [CSR_BITS-1:0] open_cost, step_cost, match, mismatch,
                            input int send_pct, stall_pct, input bit with_full);
      int first_issued;
      settle();
      write_config(open_cost, step_cost, match, mismatch);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      first_issued  = issued;
      if (with_full)
         random_sequence(1'b1);
      while (issued - first_issued < PHASE_ITEMS)
         random_sequence(1'b0);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // both empty, one side empty, single match, single mismatch (all cells zero)
      send_request(OP_RUN, 8'h00);
      send_request(OP_REF, 8'hFF);
      send_request(OP_RUN, 8'hFF);
      send_request(OP_QUERY, 8'h00);
      send_request(OP_RUN, 8'h00);
      send_request(OP_REF, 8'hFF);
      send_request(OP_QUERY, 8'hFF);
      send_request(OP_RUN, 8'h00);
      send_request(OP_REF, 8'h00);
      send_request(OP_QUERY, 8'hFF);
      send_request(OP_RUN, 8'hFF);
      // unused op between loads, then a short alignment across a gap
      send_request(OP_UNUSED, 8'hAA);
      send_request(OP_REF, 8'h41);
      send_request(OP_REF, 8'h43);
      send_request(OP_QUERY, 8'h41);
      send_request(OP_REF, 8'h47);
      send_request(OP_QUERY, 8'h47);
      send_request(OP_REF, 8'h54);
      send_request(OP_QUERY, 8'h54);
      send_request(OP_RUN, 8'h55);

      run_phase(6'd63, 6'd63, 6'd31, 6'd31, 0, 0, 1'b1);
      run_phase(6'd0, 6'd0, 6'd0, 6'b100000, 55, 0, 1'b0);
      run_phase(CSR_BITS'($urandom_range(0, 63)), CSR_BITS'($urandom_range(0, 63)),
                CSR_BITS'($urandom_range(0, 63)), CSR_BITS'($urandom_range(0, 63)),
                0, 55, 1'b0);
      run_phase(6'd5, 6'd1, 6'd2, 6'b111101, 11, 11, 1'b0);
      run_phase(CSR_BITS'($urandom_range(0, 63)), CSR_BITS'($urandom_range(0, 63)),
                CSR_BITS'($urandom_range(0, 63)), CSR_BITS'($urandom_range(0, 63)),
                0, 0, 1'b0);
      run_phase(6'd1, 6'd0, 6'd31, 6'b100000, 55, 0, 1'b1);
      run_phase(CSR_BITS'($urandom_range(0, 63)), CSR_BITS'($urandom_range(0, 63)),
                CSR_BITS'($urandom_range(0, 63)), CSR_BITS'($urandom_range(0, 63)),
                0, 55, 1'b0);

      settle();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
